// ===== hw/rtl/uspf_pkg.sv =====
// ----------------------------------------------------------------------------
// uspf_pkg
// Shared types and constants for the udp source port packet filter.
// ----------------------------------------------------------------------------
package uspf_pkg;

  // default sizing
  localparam int MAX_PAYLOAD_BYTES_DEF = 512;
  localparam int POSITION_BITS_DEF     = 16;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // field widths
  localparam int BYTE_W         = 8;
  localparam int FAMILY_W       = 2;
  localparam int KIND_W         = 2;
  localparam int PAYLOAD_SIZE_W = 10;
  localparam int PORT_W         = 16;
  localparam int PROTO_W        = 8;
  localparam int OFFSET_W       = 6;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_ADDR_W     = 3;

  // register reset values
  localparam logic [PORT_W-1:0]  MATCH_PORT_RST  = 16'd53;
  localparam logic [PROTO_W-1:0] MATCH_PROTO_RST = 8'd17;

  // register indexes (paddr bit 2)
  localparam logic REG_MATCH_PORT  = 1'b0;
  localparam logic REG_MATCH_PROTO = 1'b1;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_BYTE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COMMIT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DISCARD = 2'd2;

  // address families
  localparam logic [FAMILY_W-1:0] FAM_IPV4 = 2'd0;
  localparam logic [FAMILY_W-1:0] FAM_IPV6 = 2'd1;

  // header geometry
  localparam logic [OFFSET_W-1:0] IPV6_OFFSET    = 6'd40;
  localparam int                  IPV4_HDR_LEN   = 20;
  localparam int                  IPV6_HDR_LEN   = 40;
  localparam int                  UDP_HDR_LEN    = 8;
  localparam int                  IPV4_PROTO_POS = 9;
  localparam int                  IPV6_PROTO_POS = 6;

  // classified item handed from front to back
  typedef struct packed {
    logic                      emit_byte;
    logic [BYTE_W-1:0]         data;
    logic                      emit_close;
    logic                      commit;
    logic [PAYLOAD_SIZE_W-1:0] size;
  } uspf_entry_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } uspf_qstat_t;

endpackage

// ===== hw/rtl/uspf_if.sv =====
// ----------------------------------------------------------------------------
// uspf_if
// Valid/ready channels for packet bytes in and filter results out.
// ----------------------------------------------------------------------------
interface uspf_in_if;
  import uspf_pkg::*;

  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   pkt_byte;
  logic                first_byte;
  logic                last_byte;
  logic [FAMILY_W-1:0] addr_family;
  logic                has_socket;

  modport source (
    output valid, pkt_byte, first_byte, last_byte, addr_family, has_socket,
    input  ready
  );
  modport sink (
    input  valid, pkt_byte, first_byte, last_byte, addr_family, has_socket,
    output ready
  );
endinterface

interface uspf_out_if;
  import uspf_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic [BYTE_W-1:0]         out_byte;
  logic [PAYLOAD_SIZE_W-1:0] payload_size;
  logic                      end_of_packet;

  modport source (
    output valid, kind, out_byte, payload_size, end_of_packet,
    input  ready
  );
  modport sink (
    input  valid, kind, out_byte, payload_size, end_of_packet,
    output ready
  );
endinterface

// ===== hw/rtl/udp_source_port_packet_filter_top.sv =====
// Results of an accepted item pass through the queue and then the registered output stage.
// Throughput: one packet byte per cycle while the queue is not full; a final byte that also
//   carries a payload byte yields two results, absorbed by the 4-entry queue.
// Output rate is one result per cycle while out_ch.ready is high, set by the registered output stage.
// Reset: synchronous active-low rst_n clears packet state, queue and output valid,
//   and sets match_source_port to 53 and match_protocol to 17.
// ----------------------------------------------------------------------------
// udp_source_port_packet_filter_top
// UDP source port filter over a byte stream of IPv4/IPv6 packets.
// ----------------------------------------------------------------------------
module udp_source_port_packet_filter_top #(
  parameter int MAX_PAYLOAD_BYTES = uspf_pkg::MAX_PAYLOAD_BYTES_DEF,
  parameter int POSITION_BITS     = uspf_pkg::POSITION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  uspf_in_if.sink                         in_ch,
  uspf_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [uspf_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [uspf_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [uspf_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import uspf_pkg::*;

  logic        q_push, q_pop;
  uspf_entry_t q_in, q_head;
  uspf_qstat_t q_stat;

  // classify
  uspf_front #(
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES),
    .POSITION_BITS     (POSITION_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .qstat      (q_stat),
    .push       (q_push),
    .push_entry (q_in)
  );

  // decouple
  uspf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .qstat      (q_stat)
  );

  // emit results
  uspf_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_head),
    .qstat  (q_stat),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

  // front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("item pushed into full queue");

  // back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("item popped from empty queue");

  // only closing results end a packet, and only commit results carry a size
  a_eop_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.end_of_packet == (out_ch.kind != KIND_BYTE)) &&
                     ((out_ch.kind == KIND_COMMIT) || (out_ch.payload_size == '0)))
    else $error("closing flag or size does not match result kind");

  // reset leaves the queue empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> q_stat.empty)
    else $error("queue not empty after reset");

endmodule

// ===== hw/rtl/uspf_front.sv =====
// ----------------------------------------------------------------------------
// uspf_front
// Tracks byte position, captures header fields and classifies each item.
// ----------------------------------------------------------------------------
module uspf_front #(
  parameter int MAX_PAYLOAD_BYTES = uspf_pkg::MAX_PAYLOAD_BYTES_DEF,
  parameter int POSITION_BITS     = uspf_pkg::POSITION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  uspf_in_if.sink                             in_ch,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [uspf_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [uspf_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [uspf_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  input  uspf_pkg::uspf_qstat_t               qstat,
  output logic                                push,
  output uspf_pkg::uspf_entry_t               push_entry
);
  import uspf_pkg::*;

  localparam int PW    = POSITION_BITS;
  localparam int CNT_W = $clog2(MAX_PAYLOAD_BYTES + 1);
  localparam int LW    = (PW + 1 > 17) ? PW + 1 : 17;
  localparam logic [PW-1:0]    POS_LIMIT = {PW{1'b1}};
  localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_PAYLOAD_BYTES);

  // configuration registers
  logic [PORT_W-1:0]  match_port_r;
  logic [PROTO_W-1:0] match_proto_r;
  logic               cfg_wr;

  // packet state
  logic [PW-1:0]       pos_r, pos_nxt;
  logic [FAMILY_W-1:0] fam_r, fam_nxt;
  logic                sock_r, sock_nxt;
  logic [OFFSET_W-1:0] toff_r, toff_nxt;
  logic [PROTO_W-1:0]  proto_r, proto_nxt;
  logic [PORT_W-1:0]   sport_r, sport_nxt;
  logic [15:0]         ulen_r, ulen_nxt;
  logic [CNT_W-1:0]    pcnt_r, pcnt_nxt;
  logic                povf_r, povf_nxt;

  // per-item working values
  logic                accept;
  logic [BYTE_W-1:0]   b;
  logic [PW-1:0]       p;
  logic [FAMILY_W-1:0] cur_fam;
  logic                cur_sock;
  logic [OFFSET_W-1:0] cur_toff;
  logic [PROTO_W-1:0]  cur_proto;
  logic [PORT_W-1:0]   cur_sport;
  logic [15:0]         cur_ulen;
  logic [CNT_W-1:0]    cur_pcnt;
  logic                cur_povf;
  logic                is_v4, is_v6, known;
  logic [LW-1:0]       p_ext, off_ext, len;
  logic                pay_zone, room, emit_byte, drop;
  logic [LW-1:0]       hdr_len;

  // apb register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_port_r  <= MATCH_PORT_RST;
      match_proto_r <= MATCH_PROTO_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_MATCH_PORT:  match_port_r  <= pwdata[PORT_W-1:0];
        REG_MATCH_PROTO: match_proto_r <= pwdata[PROTO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MATCH_PORT:  prdata = CFG_DATA_W'(match_port_r);
      REG_MATCH_PROTO: prdata = CFG_DATA_W'(match_proto_r);
      default:         prdata = '0;
    endcase
  end

  // handshake
  assign in_ch.ready = !qstat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.pkt_byte;

  // state seen by this item, cleared when a packet starts
  always_comb begin
    if (in_ch.first_byte) begin
      cur_fam   = in_ch.addr_family;
      cur_sock  = in_ch.has_socket;
      cur_toff  = (in_ch.addr_family == FAM_IPV6) ? IPV6_OFFSET : '0;
      cur_proto = '0;
      cur_sport = '0;
      cur_ulen  = '0;
      cur_pcnt  = '0;
      cur_povf  = 1'b0;
      p         = '0;
    end else begin
      cur_fam   = fam_r;
      cur_sock  = sock_r;
      cur_toff  = toff_r;
      cur_proto = proto_r;
      cur_sport = sport_r;
      cur_ulen  = ulen_r;
      cur_pcnt  = pcnt_r;
      cur_povf  = povf_r;
      p         = pos_r;
    end
  end

  // field capture by position
  always_comb begin
    is_v4 = (cur_fam == FAM_IPV4);
    is_v6 = (cur_fam == FAM_IPV6);
    known = is_v4 || is_v6;

    toff_nxt = (is_v4 && p == '0) ? {b[3:0], 2'b00} : cur_toff;
    p_ext    = LW'(p);
    off_ext  = LW'(toff_nxt);

    proto_nxt = cur_proto;
    if (known && ((is_v4 && p == PW'(IPV4_PROTO_POS)) ||
                  (is_v6 && p == PW'(IPV6_PROTO_POS)))) begin
      proto_nxt = b;
    end

    sport_nxt = cur_sport;
    ulen_nxt  = cur_ulen;
    if (known) begin
      if (p_ext == off_ext)              sport_nxt[15:8] = b;
      if (p_ext == off_ext + LW'(1))     sport_nxt[7:0]  = b;
      if (p_ext == off_ext + LW'(4))     ulen_nxt[15:8]  = b;
      if (p_ext == off_ext + LW'(5))     ulen_nxt[7:0]   = b;
    end

    // payload streaming up to the size limit
    pay_zone  = known && (p_ext >= off_ext + LW'(UDP_HDR_LEN));
    room      = cur_pcnt < MAX_CNT;
    emit_byte = pay_zone && room;
    pcnt_nxt  = cur_pcnt + CNT_W'(emit_byte);
    povf_nxt  = cur_povf || (pay_zone && !room);
  end

  // verdict on the final byte
  always_comb begin
    len     = p_ext + LW'(1);
    hdr_len = is_v6 ? LW'(IPV6_HDR_LEN) : LW'(IPV4_HDR_LEN);
    drop    = !cur_sock || !known || (p == POS_LIMIT) || (len < hdr_len) ||
              (proto_nxt != match_proto_r) ||
              (len < off_ext + LW'(UDP_HDR_LEN)) ||
              (sport_nxt != match_port_r) || ulen_nxt[15] ||
              (len < off_ext + LW'(ulen_nxt)) || povf_nxt;
  end

  // queue entry
  always_comb begin
    push                  = accept && (emit_byte || in_ch.last_byte);
    push_entry.emit_byte  = emit_byte;
    push_entry.data       = b;
    push_entry.emit_close = in_ch.last_byte;
    push_entry.commit     = !drop;
    push_entry.size       = PAYLOAD_SIZE_W'(pcnt_nxt);
  end

  // next packet state
  always_comb begin
    fam_nxt  = cur_fam;
    sock_nxt = cur_sock;
    pos_nxt  = (p < POS_LIMIT) ? p + PW'(1) : p;
    if (in_ch.last_byte) begin
      fam_nxt   = '0;
      sock_nxt  = 1'b0;
      pos_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      fam_r   <= '0;
      sock_r  <= 1'b0;
      toff_r  <= '0;
      proto_r <= '0;
      sport_r <= '0;
      ulen_r  <= '0;
      pcnt_r  <= '0;
      povf_r  <= 1'b0;
    end else if (accept) begin
      pos_r  <= pos_nxt;
      fam_r  <= fam_nxt;
      sock_r <= sock_nxt;
      if (in_ch.last_byte) begin
        toff_r  <= '0;
        proto_r <= '0;
        sport_r <= '0;
        ulen_r  <= '0;
        pcnt_r  <= '0;
        povf_r  <= 1'b0;
      end else begin
        toff_r  <= toff_nxt;
        proto_r <= proto_nxt;
        sport_r <= sport_nxt;
        ulen_r  <= ulen_nxt;
        pcnt_r  <= pcnt_nxt;
        povf_r  <= povf_nxt;
      end
    end
  end

endmodule

// ===== hw/rtl/uspf_queue.sv =====
// ----------------------------------------------------------------------------
// uspf_queue
// Small first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module uspf_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  uspf_pkg::uspf_entry_t push_entry,
  input  logic                  pop,
  output uspf_pkg::uspf_entry_t head,
  output uspf_pkg::uspf_qstat_t qstat
);
  import uspf_pkg::*;

  uspf_entry_t         slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]   count_r, count_nxt;
  logic                do_push, do_pop;

  assign qstat.full  = (count_r == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign qstat.empty = (count_r == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = slot_r[rd_ptr_r];

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + (QUEUE_AW + 1)'(1);
    if (do_pop && !do_push) count_nxt = count_r - (QUEUE_AW + 1)'(1);
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + QUEUE_AW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + QUEUE_AW'(1);
      count_r <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_entry;
  end

endmodule

// ===== hw/rtl/uspf_back.sv =====
// ----------------------------------------------------------------------------
// uspf_back
// Turns queued items into result items through a registered output stage.
// ----------------------------------------------------------------------------
module uspf_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  uspf_pkg::uspf_entry_t head,
  input  uspf_pkg::uspf_qstat_t qstat,
  output logic                  pop,
  uspf_out_if.source            out_ch
);
  import uspf_pkg::*;

  logic                      out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]         kind_r, kind_nxt;
  logic [BYTE_W-1:0]         byte_r, byte_nxt;
  logic [PAYLOAD_SIZE_W-1:0] size_r, size_nxt;
  logic                      eop_r, eop_nxt;
  logic                      byte_done_r, byte_done_nxt;
  logic                      load;

  assign load = !out_valid_r || out_ch.ready;

  // pick the next result: payload byte first, then the closing verdict
  always_comb begin
    pop           = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    byte_done_nxt = byte_done_r;
    kind_nxt      = kind_r;
    byte_nxt      = byte_r;
    size_nxt      = size_r;
    eop_nxt       = eop_r;
    if (load && !qstat.empty) begin
      out_valid_nxt = 1'b1;
      if (head.emit_byte && !byte_done_r) begin
        kind_nxt      = KIND_BYTE;
        byte_nxt      = head.data;
        size_nxt      = '0;
        eop_nxt       = 1'b0;
        pop           = !head.emit_close;
        byte_done_nxt = head.emit_close;
      end else begin
        kind_nxt      = head.commit ? KIND_COMMIT : KIND_DISCARD;
        byte_nxt      = '0;
        size_nxt      = head.commit ? head.size : '0;
        eop_nxt       = 1'b1;
        pop           = 1'b1;
        byte_done_nxt = 1'b0;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      byte_done_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      byte_done_r <= byte_done_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    byte_r <= byte_nxt;
    size_r <= size_nxt;
    eop_r  <= eop_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = kind_r;
  assign out_ch.out_byte      = byte_r;
  assign out_ch.payload_size  = size_r;
  assign out_ch.end_of_packet = eop_r;

endmodule

// ===== tb/udp_source_port_packet_filter_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// udp_source_port_packet_filter_top_tb
// Self-checking bench for the udp source port filter. Packets go in byte by
// byte through a queue-fed driver, a cycle-level predictor builds the expected
// payload bytes and closing verdicts, and a monitor compares every result
// item field by field. Filter registers change between phases over apb.
// ----------------------------------------------------------------------------
module udp_source_port_packet_filter_top_tb;
  import uspf_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int POS_LIMIT    = (1 << POSITION_BITS_DEF) - 1;
  localparam int PHASE_ITEMS  = 145;
  localparam int PRINT_CAP    = 40;

  // one packet byte with its side flags
  typedef struct packed {
    logic [BYTE_W-1:0]   data;
    logic                first;
    logic                last;
    logic [FAMILY_W-1:0] family;
    logic                sock;
  } pkt_item_t;

  // one filter result item
  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic [BYTE_W-1:0]         data;
    logic [PAYLOAD_SIZE_W-1:0] size;
    logic                      eop;
  } filter_result_t;

  // ways a random packet is spoiled
  typedef enum int {
    FLAW_NONE, FLAW_NO_SOCKET, FLAW_OTHER_FAMILY, FLAW_PROTO, FLAW_PORT, FLAW_HUGE_ULEN,
    FLAW_LONG_ULEN, FLAW_TRUNCATED, FLAW_SHORT_IHL, FLAW_NO_FIRST, FLAW_NO_LAST,
    FLAW_OVERSIZE
  } pkt_flaw_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata, prdata;
  logic pready;

  uspf_in_if  in_ch();
  uspf_out_if out_ch();

  udp_source_port_packet_filter_top uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  pkt_item_t      pending_bytes[$];
  filter_result_t expected_results[$];
  int             mismatch_count = 0;
  int             items_queued = 0;
  bit             hold_gaps = 1'b0;

  // filter registers as the predictor sees them
  logic [PORT_W-1:0]  match_port;
  logic [PROTO_W-1:0] match_proto;

  // per-packet parse state
  logic [POSITION_BITS_DEF-1:0] pos_count;
  logic [FAMILY_W-1:0]          pkt_family;
  logic                         pkt_socket;
  logic [OFFSET_W-1:0]          udp_offset;
  logic [PROTO_W-1:0]           ip_proto;
  logic [PORT_W-1:0]            udp_sport;
  logic [15:0]                  udp_len;
  logic [PAYLOAD_SIZE_W-1:0]    payload_bytes;
  logic                         payload_over;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) begin
      $display("[%0t] filter mismatch: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  function automatic void clear_packet_state();
    pos_count     = '0;
    pkt_family    = FAM_IPV4;
    pkt_socket    = 1'b0;
    udp_offset    = '0;
    ip_proto      = '0;
    udp_sport     = '0;
    udp_len       = '0;
    payload_bytes = '0;
    payload_over  = 1'b0;
  endfunction

  function automatic void expect_result(input logic [KIND_W-1:0] kind,
                                        input logic [BYTE_W-1:0] data,
                                        input logic [PAYLOAD_SIZE_W-1:0] size,
                                        input logic eop);
    filter_result_t r;
    r.kind = kind;
    r.data = data;
    r.size = size;
    r.eop  = eop;
    expected_results.push_back(r);
  endfunction

  // advance the parse by one accepted byte and queue what it produces
  function automatic void predict_filter(input pkt_item_t it);
    int   p;
    int   off;
    int   len;
    int   hdr;
    logic drop;
    if (it.first) begin
      clear_packet_state();
      pkt_family = it.family;
      pkt_socket = it.sock;
      if (it.family == FAM_IPV6) udp_offset = IPV6_OFFSET;
    end
    p = pos_count;
    if (pkt_family == FAM_IPV4 && p == 0) udp_offset = {it.data[3:0], 2'b00};
    off = udp_offset;

    // header capture and payload streaming, known families only
    if (pkt_family <= FAM_IPV6) begin
      if ((pkt_family == FAM_IPV4 && p == IPV4_PROTO_POS) ||
          (pkt_family == FAM_IPV6 && p == IPV6_PROTO_POS)) ip_proto = it.data;
      if (p == off)     udp_sport[15:8] = it.data;
      if (p == off + 1) udp_sport[7:0]  = it.data;
      if (p == off + 4) udp_len[15:8]   = it.data;
      if (p == off + 5) udp_len[7:0]    = it.data;
      if (p >= off + UDP_HDR_LEN) begin
        if (payload_bytes < MAX_PAYLOAD_BYTES_DEF) begin
          expect_result(KIND_BYTE, it.data, '0, 1'b0);
          payload_bytes = payload_bytes + 1'b1;
        end else begin
          payload_over = 1'b1;
        end
      end
    end

    // closing verdict
    if (it.last) begin
      len  = p + 1;
      hdr  = (pkt_family == FAM_IPV6) ? IPV6_HDR_LEN : IPV4_HDR_LEN;
      drop = !pkt_socket || pkt_family > FAM_IPV6 || p >= POS_LIMIT || len < hdr ||
             ip_proto != match_proto || len < off + UDP_HDR_LEN ||
             udp_sport != match_port || udp_len >= 16'h8000 ||
             len < off + int'(udp_len) || payload_over;
      if (drop) expect_result(KIND_DISCARD, '0, '0, 1'b1);
      else      expect_result(KIND_COMMIT, '0, payload_bytes, 1'b1);
      clear_packet_state();
    end else if (p < POS_LIMIT) begin
      pos_count = pos_count + 1'b1;
    end
  endfunction

  // input driver: one item per handshake, random gaps in stretches
  int in_gap = 0;
  int in_stretch = 0;
  bit in_calm = 1'b0;
  pkt_item_t next_item;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_filter({in_ch.pkt_byte, in_ch.first_byte, in_ch.last_byte,
                        in_ch.addr_family, in_ch.has_socket});
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          next_item = pending_bytes.pop_front();
          in_ch.pkt_byte    <= next_item.data;
          in_ch.first_byte  <= next_item.first;
          in_ch.last_byte   <= next_item.last;
          in_ch.addr_family <= next_item.family;
          in_ch.has_socket  <= next_item.sock;
          in_ch.valid       <= 1'b1;
          if (in_stretch == 0) begin
            in_stretch = $urandom_range(1, 64);
            in_calm    = ($urandom_range(0, 2) == 0);
          end
          in_stretch--;
          in_gap = (hold_gaps || in_calm) ? 0 : $urandom_range(0, 8);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: compare against the oldest expectation, random stalls
  int out_stall = 0;
  int out_stretch = 0;
  bit out_calm = 1'b0;
  filter_result_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d byte %02h size %0d eop %0b",
                                    out_ch.kind, out_ch.out_byte, out_ch.payload_size,
                                    out_ch.end_of_packet));
        end else begin
          want = expected_results.pop_front();
          if (out_ch.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", out_ch.kind, want.kind));
          if (out_ch.out_byte !== want.data)
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      out_ch.out_byte, want.data));
          if (out_ch.payload_size !== want.size)
            report_mismatch($sformatf("payload_size %0d, expected %0d",
                                      out_ch.payload_size, want.size));
          if (out_ch.end_of_packet !== want.eop)
            report_mismatch($sformatf("end_of_packet %0b, expected %0b",
                                      out_ch.end_of_packet, want.eop));
        end
        if (out_stretch == 0) begin
          out_stretch = $urandom_range(1, 64);
          out_calm    = ($urandom_range(0, 2) == 0);
        end
        out_stretch--;
        out_stall = out_calm ? 0 : $urandom_range(0, 8);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic queue_item(input logic [7:0] data, input logic first, input logic last,
                            input logic [1:0] family, input logic sock);
    pkt_item_t it;
    it.data   = data;
    it.first  = first;
    it.last   = last;
    it.family = family;
    it.sock   = sock;
    pending_bytes.push_back(it);
    items_queued++;
  endtask

  // lay out one packet with random filler and queue its bytes
  task automatic queue_packet(input logic [1:0] fam, input logic sock, input logic [3:0] ihl,
                              input logic [7:0] proto, input logic [15:0] sport,
                              input logic [15:0] ulen, input int total,
                              input bit with_first, input bit with_last);
    logic [7:0] pkt[];
    int off;
    bit head;
    off = (fam == FAM_IPV6) ? IPV6_HDR_LEN : ihl * 4;
    pkt = new[total];
    foreach (pkt[i]) pkt[i] = $urandom_range(0, 255);
    if (off < total)     pkt[off]     = sport[15:8];
    if (off + 1 < total) pkt[off + 1] = sport[7:0];
    if (off + 4 < total) pkt[off + 4] = ulen[15:8];
    if (off + 5 < total) pkt[off + 5] = ulen[7:0];
    if (fam == FAM_IPV6) begin
      pkt[0][7:4] = 4'h6;
      if (IPV6_PROTO_POS < total) pkt[IPV6_PROTO_POS] = proto;
    end else begin
      if (IPV4_PROTO_POS < total) pkt[IPV4_PROTO_POS] = proto;
      pkt[0] = {4'h4, ihl};
    end
    foreach (pkt[i]) begin
      head = (i == 0);
      queue_item(pkt[i], with_first && head, with_last && i == total - 1,
                 head ? fam : 2'($urandom_range(0, 2)), head ? sock : 1'($urandom_range(0, 1)));
    end
  endtask

  // mostly well-formed packets for the current registers, some spoiled, some noise
  task automatic queue_random_traffic();
    int r, off, plen, total, n;
    logic [1:0]  fam;
    logic        sock;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [15:0] sport, ulen;
    bit          first_ok, last_ok;
    pkt_flaw_t   flaw;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      n = $urandom_range(1, 6);
      repeat (n) queue_item($urandom_range(0, 255), $urandom_range(0, 4) == 0,
                            $urandom_range(0, 4) == 0, $urandom_range(0, 2),
                            $urandom_range(0, 1));
      return;
    end
    flaw     = (r >= 60) ? pkt_flaw_t'($urandom_range(1, 11)) : FLAW_NONE;
    fam      = $urandom_range(0, 1);
    sock     = 1'b1;
    ihl      = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 4'd5;
    proto    = match_proto;
    sport    = match_port;
    plen     = ($urandom_range(0, 79) == 0) ? $urandom_range(500, 512) : $urandom_range(0, 16);
    first_ok = 1'b1;
    last_ok  = 1'b1;
    case (flaw)
      FLAW_NO_SOCKET:    sock = 1'b0;
      FLAW_OTHER_FAMILY: fam = 2'd2;
      FLAW_PROTO:        proto = proto ^ 8'($urandom_range(1, 255));
      FLAW_PORT:         sport = sport ^ 16'($urandom_range(1, 65535));
      FLAW_SHORT_IHL:    ihl = $urandom_range(0, 4);
      FLAW_NO_FIRST:     first_ok = 1'b0;
      FLAW_NO_LAST:      last_ok = 1'b0;
      FLAW_OVERSIZE:     plen = $urandom_range(513, 530);
      default: ;
    endcase
    off   = (fam == FAM_IPV6) ? IPV6_HDR_LEN : ihl * 4;
    total = off + UDP_HDR_LEN + plen;
    ulen  = UDP_HDR_LEN + (($urandom_range(0, 3) == 0) ? $urandom_range(0, plen) : plen);
    case (flaw)
      FLAW_HUGE_ULEN: ulen = $urandom_range(16'h8000, 16'hFFFF);
      FLAW_LONG_ULEN: ulen = total - off + $urandom_range(1, 40);
      FLAW_TRUNCATED: total = $urandom_range(1, off + UDP_HDR_LEN - 1);
      default: ;
    endcase
    queue_packet(fam, sock, ihl, proto, sport, ulen, total, first_ok, last_ok);
  endtask

  task automatic apb_access(input logic wr, input logic idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_filter_regs();
    logic [31:0] rd;
    apb_access(1'b0, REG_MATCH_PORT, '0, rd);
    if (rd[PORT_W-1:0] !== match_port)
      report_mismatch($sformatf("match_source_port reads %0d, expected %0d",
                                rd[PORT_W-1:0], match_port));
    apb_access(1'b0, REG_MATCH_PROTO, '0, rd);
    if (rd[PROTO_W-1:0] !== match_proto)
      report_mismatch($sformatf("match_protocol reads %0d, expected %0d",
                                rd[PROTO_W-1:0], match_proto));
  endtask

  // registers take the low bits; upper bits carry junk
  task automatic set_filter(input logic [15:0] port, input logic [7:0] proto);
    logic [31:0] wd, rd;
    wd = $urandom;
    wd[PORT_W-1:0] = port;
    apb_access(1'b1, REG_MATCH_PORT, wd, rd);
    match_port = port;
    wd = $urandom;
    wd[PROTO_W-1:0] = proto;
    apb_access(1'b1, REG_MATCH_PROTO, wd, rd);
    match_proto = proto;
    check_filter_regs();
  endtask

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("** udp_source_port_packet_filter_top: FAILED **");
    $finish;
  end

  int phase_end;

  initial begin
    rst_n              = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_ch.valid        = 1'b0;
    in_ch.pkt_byte     = '0;
    in_ch.first_byte   = 1'b0;
    in_ch.last_byte    = 1'b0;
    in_ch.addr_family  = FAM_IPV4;
    in_ch.has_socket   = 1'b0;
    out_ch.ready       = 1'b0;
    match_port         = MATCH_PORT_RST;
    match_proto        = MATCH_PROTO_RST;
    clear_packet_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    check_filter_regs();

    // directed cases on reset registers
    queue_packet(FAM_IPV4, 1, 5, 17, 53, 12, 32, 0, 1);    // bytes with no first flag
    queue_packet(FAM_IPV4, 1, 5, 17, 53, 12, 32, 1, 1);    // clean ipv4
    queue_packet(FAM_IPV6, 1, 5, 17, 53, 11, 51, 1, 1);    // clean ipv6
    queue_packet(FAM_IPV4, 1, 5, 17, 53, 8, 28, 1, 1);     // empty payload
    queue_packet(FAM_IPV4, 1, 5, 17, 53, 8, 1, 1, 1);      // one-byte packet
    queue_packet(FAM_IPV4, 0, 5, 17, 53, 12, 32, 1, 1);    // no socket
    queue_packet(2'd2, 1, 5, 17, 53, 12, 32, 1, 1);        // unknown family
    queue_packet(FAM_IPV4, 1, 5, 17, 53, 12, 12, 1, 1);    // ipv4 header cut short
    queue_packet(FAM_IPV6, 1, 5, 17, 53, 12, 30, 1, 1);    // ipv6 header cut short
    queue_packet(FAM_IPV4, 1, 5, 6, 53, 12, 32, 1, 1);     // not udp
    queue_packet(FAM_IPV6, 1, 5, 17, 54, 12, 52, 1, 1);    // wrong source port
    queue_packet(FAM_IPV4, 1, 5, 17, 53, 16'h8000, 32, 1, 1);
    queue_packet(FAM_IPV4, 1, 5, 17, 53, 16'hFFFF, 32, 1, 1);
    queue_packet(FAM_IPV4, 1, 5, 17, 53, 20, 32, 1, 1);    // udp length past the end
    queue_packet(FAM_IPV4, 1, 5, 17, 53, 8, 25, 1, 1);     // udp header cut short
    queue_packet(FAM_IPV4, 1, 15, 17, 53, 13, 73, 1, 1);   // longest ipv4 header
    queue_packet(FAM_IPV4, 1, 4, 17, 53, 14, 30, 1, 1);    // short ihl, overlapping words
    queue_packet(FAM_IPV4, 1, 0, 17, 53, 8, 24, 1, 1);     // zero ihl
    queue_packet(FAM_IPV4, 1, 5, 17, 53, 20, 24, 1, 0);    // abandoned by a restart
    queue_packet(FAM_IPV6, 1, 5, 17, 53, 10, 50, 1, 1);
    queue_packet(FAM_IPV4, 1, 5, 17, 53, 520, 540, 1, 1);  // payload at the limit
    queue_packet(FAM_IPV6, 1, 5, 17, 53, 521, 561, 1, 1);  // one byte over
    wait_idle();

    // position counter pinned at its top
    hold_gaps = 1'b1;
    queue_packet(FAM_IPV6, 1, 5, 17, 53, 100, POS_LIMIT + 2, 1, 1);
    wait_idle();
    hold_gaps = 1'b0;

    // random phases across register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       set_filter(16'h0000, 8'h00);
        1:       set_filter(16'hFFFF, 8'hFF);
        5:       set_filter($urandom_range(0, 65535), 8'd17);
        default: set_filter($urandom_range(0, 65535), $urandom_range(0, 255));
      endcase
      phase_end = items_queued + PHASE_ITEMS;
      while (items_queued < phase_end) queue_random_traffic();
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("** udp_source_port_packet_filter_top: PASSED **");
    end else begin
      $display("** udp_source_port_packet_filter_top: FAILED **");
    end
    $finish;
  end

endmodule
